>>> rtl/pgalloc_pkg.sv
package pgalloc_pkg;

    // Physical addresses and page numbers.
    localparam int ADDR_W     = 56;
    localparam int PAGE_SHIFT = 12;
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    // A rounded-up first page number needs one bit more than a page number.
    localparam int FP_W       = PN_W + 1;

    localparam int REQ_W      = 3;
    localparam int ST_W       = 3;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DROP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET   = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BADADDR = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFREE  = 3'd2;
    localparam logic [ST_W-1:0] ST_REFD    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd1;

    localparam logic [ADDR_W-1:0] BASE_RESET  = 56'h0000_0080_000000;
    localparam logic [ADDR_W-1:0] LIMIT_RESET = 56'h0000_0088_000000;

    // Region settings as seen by the request logic.
    typedef struct packed {
        logic              busy;
        logic [FP_W-1:0]   first_page;
        logic [ADDR_W-1:0] limit;
    } region_t;

    // One result item.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [CNT_W-1:0]  ref_count;
    } result_t;

endpackage

>>> rtl/pgalloc_cfg.sv
module pgalloc_cfg #(
    parameter int NUM_PAGES = 32768,
    localparam int PCNT_W = $clog2(NUM_PAGES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgalloc_pkg::ADDR_W-1:0]    cfg_data,
    output pgalloc_pkg::region_t              region,
    output logic [PCNT_W-1:0]                 pool_pages
);
    import pgalloc_pkg::*;

    logic [ADDR_W-1:0] base_reg, limit_reg;
    logic [FP_W-1:0]   fp_reg;
    logic [PCNT_W-1:0] pool_reg;
    // Counts down the two derivation steps after reset or a write.
    logic [1:0]        upd_reg;

    logic [ADDR_W:0]   base_round;
    logic [FP_W-1:0]   last_page;
    logic [FP_W-1:0]   span;
    logic [PCNT_W-1:0] pool_next;

    assign cfg_ready  = 1'b1;
    assign base_round = {1'b0, base_reg} + (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);
    assign last_page  = {1'b0, limit_reg[ADDR_W-1:PAGE_SHIFT]};
    assign span       = last_page - fp_reg;

    always_comb
    begin
        if (last_page <= fp_reg)
        begin
            pool_next = '0;
        end
        else if (span > FP_W'(NUM_PAGES))
        begin
            pool_next = PCNT_W'(NUM_PAGES);
        end
        else
        begin
            pool_next = span[PCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            limit_reg <= LIMIT_RESET;
            fp_reg    <= '0;
            pool_reg  <= '0;
            upd_reg   <= 2'd2;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == CFG_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
                upd_reg <= 2'd2;
            end
            else if (upd_reg == 2'd2)
            begin
                fp_reg  <= base_round[ADDR_W:PAGE_SHIFT];
                upd_reg <= 2'd1;
            end
            else if (upd_reg == 2'd1)
            begin
                pool_reg <= pool_next;
                upd_reg  <= 2'd0;
            end
        end
    end

    assign region.busy       = (upd_reg != 2'd0);
    assign region.first_page = fp_reg;
    assign region.limit      = limit_reg;
    assign pool_pages        = pool_reg;

endmodule

>>> rtl/pgalloc_outreg.sv
module pgalloc_outreg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pgalloc_pkg::result_t res,
    output logic                 can_load,
    output logic                 empty,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,
    output logic [2:0]           m_axis_tuser
);
    import pgalloc_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || m_axis_tready;
    assign empty    = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && can_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.ref_count, res_reg.alloc_addr};
    assign m_axis_tuser  = res_reg.status;

endmodule

>>> rtl/pgalloc_core.sv
module pgalloc_core #(
    parameter int NUM_PAGES = 32768,
    localparam int PCNT_W = $clog2(NUM_PAGES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pgalloc_pkg::REQ_W-1:0]  in_req,
    input  logic [pgalloc_pkg::ADDR_W-1:0] in_addr,
    input  pgalloc_pkg::region_t           region,
    input  logic [PCNT_W-1:0]              pool_pages,
    input  logic                           out_can_load,
    input  logic                           out_empty,
    output logic                           out_load,
    output pgalloc_pkg::result_t           out_res
);
    import pgalloc_pkg::*;

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    localparam logic [2:0] ACT_BAD   = 3'd0;
    localparam logic [2:0] ACT_NONE  = 3'd1;
    localparam logic [2:0] ACT_POP   = 3'd2;
    localparam logic [2:0] ACT_FRESH = 3'd3;
    localparam logic [2:0] ACT_FREE  = 3'd4;
    localparam logic [2:0] ACT_ADD   = 3'd5;
    localparam logic [2:0] ACT_DROP  = 3'd6;
    localparam logic [2:0] ACT_GET   = 3'd7;

    logic [1:0]        state_reg, state_next;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        act_reg, act_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PCNT_W-1:0] depth_reg, fresh_reg;
    logic              clr_active_reg;
    logic [IDX_W-1:0]  clr_idx_reg;

    logic [IDX_W-1:0]  stack_mem [NUM_PAGES];
    logic [CNT_W-1:0]  count_mem [NUM_PAGES];
    logic [IDX_W-1:0]  stack_q;
    logic [CNT_W-1:0]  count_q;

    logic              accept, fire;
    logic [FP_W-1:0]   page_num, page_off;
    logic              addr_ok;
    logic [PCNT_W-1:0] depth_m1, fresh_idx;

    logic              cnt_we, stk_we;
    logic [IDX_W-1:0]  cnt_waddr, wr_idx;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [FP_W-1:0]   page_sum;

    assign accept = in_valid && in_ready;
    assign fire   = (state_reg == S_WR) && out_can_load;
    assign in_ready = !clr_active_reg && !region.busy
                      && ((state_reg == S_IDLE) || ((state_reg == S_WR) && out_empty));

    // Address check and choice of page, done while the memories are read.
    assign page_num = {1'b0, addr_reg[ADDR_W-1:PAGE_SHIFT]};
    assign page_off = page_num - region.first_page;
    assign addr_ok  = (addr_reg[PAGE_SHIFT-1:0] == '0)
                      && (addr_reg < region.limit)
                      && (page_num >= region.first_page)
                      && (page_off < FP_W'(NUM_PAGES));
    assign depth_m1  = depth_reg - 1'b1;
    assign fresh_idx = pool_pages - 1'b1 - fresh_reg;

    always_comb
    begin
        act_next = ACT_BAD;
        idx_next = page_off[IDX_W-1:0];
        case (req_reg)
            REQ_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    act_next = ACT_POP;
                end
                else if (fresh_reg < pool_pages)
                begin
                    act_next = ACT_FRESH;
                    idx_next = fresh_idx[IDX_W-1:0];
                end
                else
                begin
                    act_next = ACT_NONE;
                end
            end
            REQ_FREE: act_next = addr_ok ? ACT_FREE : ACT_BAD;
            REQ_ADD:  act_next = addr_ok ? ACT_ADD  : ACT_BAD;
            REQ_DROP: act_next = addr_ok ? ACT_DROP : ACT_BAD;
            REQ_GET:  act_next = addr_ok ? ACT_GET  : ACT_BAD;
            default:  act_next = ACT_BAD;
        endcase
    end

    // Write-back and result, taken only when the output register has room.
    assign wr_idx   = (act_reg == ACT_POP) ? stack_q : idx_reg;
    assign page_sum = region.first_page + FP_W'(wr_idx);

    always_comb
    begin
        cnt_we            = 1'b0;
        stk_we            = 1'b0;
        cnt_wdata         = '0;
        out_res.status    = ST_BADADDR;
        out_res.alloc_addr = '0;
        out_res.ref_count = '0;
        case (act_reg)
            ACT_POP, ACT_FRESH:
            begin
                cnt_we             = 1'b1;
                cnt_wdata          = CNT_W'(1);
                out_res.status     = ST_OK;
                out_res.alloc_addr = {page_sum[PN_W-1:0], {PAGE_SHIFT{1'b0}}};
                out_res.ref_count  = CNT_W'(1);
            end
            ACT_NONE:
            begin
                out_res.status = ST_NOFREE;
            end
            ACT_FREE:
            begin
                if (count_q != '0)
                begin
                    out_res.status    = ST_REFD;
                    out_res.ref_count = count_q;
                end
                else if (depth_reg == PCNT_W'(NUM_PAGES))
                begin
                    out_res.status = ST_FULL;
                end
                else
                begin
                    stk_we         = 1'b1;
                    out_res.status = ST_OK;
                end
            end
            ACT_ADD:
            begin
                cnt_we            = 1'b1;
                cnt_wdata         = count_q + 1'b1;
                out_res.status    = ST_OK;
                out_res.ref_count = cnt_wdata;
            end
            ACT_DROP:
            begin
                cnt_we            = 1'b1;
                cnt_wdata         = count_q - 1'b1;
                out_res.status    = ST_OK;
                out_res.ref_count = cnt_wdata;
            end
            ACT_GET:
            begin
                out_res.status    = ST_OK;
                out_res.ref_count = count_q;
            end
            default:
            begin
                out_res.status = ST_BADADDR;
            end
        endcase
    end

    assign out_load  = fire;
    assign cnt_waddr = clr_active_reg ? clr_idx_reg : wr_idx;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_RD;
            S_RD:   state_next = S_WR;
            S_WR:   if (fire) state_next = accept ? S_RD : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            fresh_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active_reg)
            begin
                if (clr_idx_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end
            if (fire)
            begin
                if (act_reg == ACT_POP)
                begin
                    depth_reg <= depth_m1;
                end
                else if (stk_we)
                begin
                    depth_reg <= depth_reg + 1'b1;
                end
                if (act_reg == ACT_FRESH)
                begin
                    fresh_reg <= fresh_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= in_req;
            addr_reg <= in_addr;
        end
        if (state_reg == S_RD)
        begin
            act_reg <= act_next;
            idx_reg <= idx_next;
        end
    end

    // Stack of freed page indexes; the read at one below the depth is used only by a pop.
    always_ff @(posedge clk)
    begin
        if (fire && stk_we)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= idx_reg;
        end
        if (state_reg == S_RD)
        begin
            stack_q <= stack_mem[depth_m1[IDX_W-1:0]];
        end
    end

    // Reference counts, swept to zero after reset.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg || (fire && cnt_we))
        begin
            count_mem[cnt_waddr] <= clr_active_reg ? '0 : cnt_wdata;
        end
        if (state_reg == S_RD)
        begin
            count_q <= count_mem[idx_next];
        end
    end

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= PCNT_W'(NUM_PAGES))
        else $error("free stack depth beyond capacity");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg != $past(depth_reg)) |-> ($past(fire)
            && (depth_reg == $past(depth_reg) + 1'b1 || depth_reg == $past(depth_reg) - 1'b1)))
        else $error("free stack depth moved without a completed request");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> ($past(state_reg) == S_RD || $past(state_reg) == S_WR))
        else $error("write-back without a preceding memory read");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (state_reg == S_IDLE && !in_ready))
        else $error("request in flight during count clearing");

    a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= PCNT_W'(NUM_PAGES))
        else $error("untouched page counter beyond capacity");

endmodule

>>> rtl/page_allocator_with_refcounts.sv
// Page allocator with per-page reference counts.
// Requests enter on the s_axis channel: tuser carries the request type
// (allocate, free, add reference, drop reference, read count) and tdata the
// page address. Each request produces exactly one result transaction on the
// m_axis channel: tuser carries the status, tdata the allocated address and
// the page's count after the request.
// Region base and limit are written over the cfg channel (index 0 is the
// base, index 1 the limit); the user must write them only while no request
// is outstanding, which the block itself does not enforce. The first page
// is then derived from the base and the pool size from the first page;
// requests are held off until both have settled. A request first checks the
// address and reads the count and stack memories, then writes them back and
// loads the result register once it has room. The next request is accepted
// in the write-back cycle when the result register is empty; requests
// overlap only there, since each one reads and then writes the count memory.
// After reset the count memory is swept to zero, one entry per cycle, so
// s_axis_tready stays low until every entry is cleared.
// When the receiver stalls, the finished result waits in the output register
// and one further request may be read; it is written back only once the
// output register has room, and s_axis_tready stays low meanwhile.
module page_allocator_with_refcounts #(
    parameter int NUM_PAGES = 32768
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // page_addr[55:0]
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // alloc_addr[55:0], ref_count[63:56]
    output logic [2:0]  m_axis_tuser,   // status[2:0]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [55:0] cfg_data
);
    import pgalloc_pkg::*;

    localparam int PCNT_W = $clog2(NUM_PAGES + 1);

    region_t           region;
    logic [PCNT_W-1:0] pool_pages;
    result_t           res;
    logic              out_load, out_can_load, out_empty;

    // Region registers and the first page and pool size derived from them.
    pgalloc_cfg #(
        .NUM_PAGES (NUM_PAGES)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .region     (region),
        .pool_pages (pool_pages)
    );

    // Request sequencer with the free stack and count memories.
    pgalloc_core #(
        .NUM_PAGES (NUM_PAGES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_req       (s_axis_tuser),
        .in_addr      (s_axis_tdata),
        .region       (region),
        .pool_pages   (pool_pages),
        .out_can_load (out_can_load),
        .out_empty    (out_empty),
        .out_load     (out_load),
        .out_res      (res)
    );

    // Result register that decouples the receiver from the sequencer.
    pgalloc_outreg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .res           (res),
        .can_load      (out_can_load),
        .empty         (out_empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> tb/page_allocator_with_refcounts_tb.sv
module page_allocator_with_refcounts_tb;

    import pgalloc_pkg::*;

    localparam int NUM_PAGES = 32768;
    // Acceptance-to-result delay of the block, used for the drain wait.
    localparam int LATENCY = 2;
    localparam int DRAIN_CYCLES = 2 * LATENCY;
    // The count memory sweep after reset keeps the request side closed until
    // all entries are cleared: the longest quiet stretch of a correct run.
    localparam int WATCHDOG_LIMIT = 4 * NUM_PAGES + 2000;
    localparam int HOLD_CYCLES = 300;

    // Mirror of the allocator: region registers, free stack, untouched page
    // counter and the per-page counts. Each accepted request is applied here
    // and its result joins the queue of results still due from the block.
    class page_ledger #(int PAGES = 32768);
        bit [ADDR_W-1:0] base = BASE_RESET;
        bit [ADDR_W-1:0] limit = LIMIT_RESET;
        bit [7:0] counts [PAGES];
        int unsigned stack_idx [PAGES];
        int unsigned depth;
        int unsigned fresh;
        result_t due_results [$];
        int unsigned mismatch_count;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
            if (idx == CFG_BASE)
                base = value;
            else if (idx == CFG_LIMIT)
                limit = value;
        endfunction

        function bit [63:0] first_page();
            return ({8'd0, base} + 64'hFFF) >> PAGE_SHIFT;
        endfunction

        function bit [63:0] pool_size();
            bit [63:0] fp;
            bit [63:0] lp;
            bit [63:0] n;
            fp = first_page();
            lp = {8'd0, limit} >> PAGE_SHIFT;
            n = (lp > fp) ? lp - fp : 64'd0;
            return (n > PAGES) ? 64'(PAGES) : n;
        endfunction

        function bit page_index(bit [ADDR_W-1:0] addr, output int unsigned idx);
            bit [63:0] pg;
            bit [63:0] fp;
            idx = 0;
            if (addr[PAGE_SHIFT-1:0] != '0 || addr >= limit)
                return 1'b0;
            pg = {8'd0, addr} >> PAGE_SHIFT;
            fp = first_page();
            if (pg < fp || pg - fp >= PAGES)
                return 1'b0;
            idx = 32'(pg - fp);
            return 1'b1;
        endfunction

        function result_t apply_request(bit [REQ_W-1:0] req, bit [ADDR_W-1:0] addr);
            result_t res;
            int unsigned idx;
            bit [63:0] n;
            bit [63:0] pa;
            res.status = ST_BADADDR;
            res.alloc_addr = '0;
            res.ref_count = '0;
            idx = 0;
            if (req == REQ_ALLOC)
            begin
                n = pool_size();
                if (depth > 0)
                begin
                    depth--;
                    idx = stack_idx[depth] % PAGES;
                end
                else if (fresh < n)
                begin
                    idx = 32'(n - 1 - fresh);
                    fresh++;
                end
                else
                begin
                    res.status = ST_NOFREE;
                end
                if (res.status != ST_NOFREE)
                begin
                    counts[idx] = 8'd1;
                    pa = (first_page() + idx) << PAGE_SHIFT;
                    res.status = ST_OK;
                    res.alloc_addr = pa[ADDR_W-1:0];
                    res.ref_count = 8'd1;
                end
            end
            else if (req <= REQ_GET && page_index(addr, idx))
            begin
                if (req == REQ_FREE)
                begin
                    if (counts[idx] != 0)
                    begin
                        res.status = ST_REFD;
                        res.ref_count = counts[idx];
                    end
                    else if (depth >= PAGES)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        stack_idx[depth] = idx;
                        depth++;
                        res.status = ST_OK;
                    end
                end
                else
                begin
                    if (req == REQ_ADD)
                        counts[idx] = counts[idx] + 8'd1;
                    else if (req == REQ_DROP)
                        counts[idx] = counts[idx] - 8'd1;
                    res.status = ST_OK;
                    res.ref_count = counts[idx];
                end
            end
            due_results.push_back(res);
            return res;
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: %s expected %0h actual %0h", what, want, got);
        endfunction

        function void compare_result(logic [ST_W-1:0] status, logic [ADDR_W-1:0] alloc_addr,
                                     logic [CNT_W-1:0] ref_count);
            result_t want;
            if (due_results.size() == 0)
            begin
                flag("result with none due", '0, {status, alloc_addr});
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status)
                flag("status", want.status, status);
            if (alloc_addr !== want.alloc_addr)
                flag("alloc_addr", want.alloc_addr, alloc_addr);
            if (ref_count !== want.ref_count)
                flag("ref_count", want.ref_count, ref_count);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [ADDR_W-1:0] s_axis_tdata = '0;    // page_addr[55:0]
    logic [REQ_W-1:0]  s_axis_tuser = '0;    // req_type[2:0]

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;         // alloc_addr[55:0], ref_count[63:56]
    logic [ST_W-1:0]   m_axis_tuser;         // status[2:0]

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data = '0;

    page_ledger #(NUM_PAGES) ledger;

    // When set, neither side inserts idle cycles.
    bit no_idle = 1'b0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;

    always #4 clk = ~clk;

    page_allocator_with_refcounts #(
        .NUM_PAGES(NUM_PAGES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // A page address inside the current pool, taken from either end of it so
    // that both recycled low pages and freshly handed-out top pages are hit.
    function automatic logic [ADDR_W-1:0] pool_page_addr();
        bit [63:0] fp;
        bit [63:0] n;
        bit [63:0] span;
        bit [63:0] pg;
        fp = ledger.first_page();
        n = ledger.pool_size();
        span = (n > 16) ? 64'd16 : n;
        if (n == 0)
            pg = fp + $urandom_range(0, 3);
        else if ($urandom_range(0, 1) == 0)
            pg = fp + $urandom_range(0, 32'(span) - 1);
        else
            pg = fp + n - 1 - $urandom_range(0, 32'(span) - 1);
        return ADDR_W'(pg << PAGE_SHIFT);
    endfunction

    // Addresses that the block has to refuse, plus the odd random one.
    function automatic logic [ADDR_W-1:0] bad_addr();
        bit [63:0] fp;
        fp = ledger.first_page();
        case ($urandom_range(0, 4))
            0: return any_addr();
            1: return pool_page_addr() | ADDR_W'($urandom_range(1, 4095));
            2: return ADDR_W'((fp - 1) << PAGE_SHIFT);
            3: return ledger.limit;
            default: return ADDR_W'((fp + NUM_PAGES) << PAGE_SHIFT);
        endcase
    endfunction

    // Offers one request and returns once the transaction has been accepted,
    // with the result the block owes for it.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                         output result_t due);
        int unsigned gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= addr;
        do @(posedge clk); while (!s_axis_tready);
        due = ledger.apply_request(req, addr);
        items_sent++;
    endtask

    // Registers are only written with nothing outstanding. An extra drain wait
    // lets the last request finish inside the block before the write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (ledger.due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_register(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
        write_register(CFG_BASE, base);
        write_register(CFG_LIMIT, limit);
    endtask

    // Well-formed use of one page: allocate, take and look at references,
    // drop them all and hand the page back. Some pages stay allocated, some
    // are freed too early, and some are freed twice.
    task automatic page_lifecycle();
        result_t r;
        logic [ADDR_W-1:0] pa;
        int unsigned k;
        issue(REQ_ALLOC, any_addr(), r);
        if (r.status != ST_OK)
            return;
        pa = r.alloc_addr;
        k = $urandom_range(0, 3);
        repeat (k)
            issue(($urandom_range(0, 1) == 0) ? REQ_ADD : REQ_GET, pa, r);
        if ($urandom_range(0, 4) == 0)
            return;
        if ($urandom_range(0, 4) == 0)
            issue(REQ_FREE, pa, r);
        while (r.ref_count != 0)
            issue(REQ_DROP, pa, r);
        issue(REQ_FREE, pa, r);
        if ($urandom_range(0, 9) == 0)
            issue(REQ_FREE, pa, r);
    endtask

    task automatic single_request();
        result_t r;
        logic [REQ_W-1:0] req;
        case ($urandom_range(0, 4))
            0: req = REQ_ALLOC;
            1: req = REQ_FREE;
            2: req = REQ_ADD;
            3: req = REQ_DROP;
            default: req = REQ_GET;
        endcase
        issue(req, (req == REQ_ALLOC) ? any_addr() : pool_page_addr(), r);
    endtask

    // Refused addresses and request types past the last defined one.
    task automatic noise_request();
        result_t r;
        if ($urandom_range(0, 1) == 0)
            issue(REQ_GET + REQ_W'($urandom_range(1, 3)), any_addr(), r);
        else
            issue(REQ_W'($urandom_range(REQ_FREE, REQ_GET)), bad_addr(), r);
    endtask

    // Result side: random back-pressure, and once, while requests are being
    // offered, a long hold so the block fills up and closes its input.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned g;
        bit held;
        stall_left = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 120 && s_axis_tvalid)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (no_idle)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                g = ($urandom_range(0, 5) == 0) ? idle_gap() : 0;
                if (g == 0)
                begin
                    m_axis_tready <= 1'b1;
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    // Result checking and the watchdog. Every accepted result is compared
    // with the oldest one due; any transaction on any channel resets the
    // quiet counter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                ledger.compare_result(m_axis_tuser, m_axis_tdata[ADDR_W-1:0],
                                      m_axis_tdata[63:56]);
                results_seen++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** page_allocator_with_refcounts: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        result_t r;
        logic [ADDR_W-1:0] pa;
        int unsigned stop_at;
        int unsigned phase;
        ledger = new;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset region: the top page is handed out first.
        issue(REQ_ALLOC, '0, r);
        issue(REQ_GET, LIMIT_RESET - 56'h1000, r);
        // Free while still referenced is refused with the count.
        issue(REQ_FREE, LIMIT_RESET - 56'h1000, r);
        issue(REQ_DROP, LIMIT_RESET - 56'h1000, r);
        issue(REQ_FREE, LIMIT_RESET - 56'h1000, r);
        // The freed page comes back from the stack.
        issue(REQ_ALLOC, {ADDR_W{1'b1}}, r);
        // Misaligned, below the base and at the limit are all bad addresses.
        issue(REQ_FREE, LIMIT_RESET - 56'h800, r);
        issue(REQ_ADD, BASE_RESET - 56'h1000, r);
        issue(REQ_GET, LIMIT_RESET, r);
        // Counts wrap both ways on an untouched page.
        issue(REQ_GET, BASE_RESET, r);
        issue(REQ_DROP, BASE_RESET, r);
        issue(REQ_ADD, BASE_RESET, r);
        // A page that was never allocated is pushed like any other.
        issue(REQ_FREE, BASE_RESET, r);
        issue(REQ_GET + 3'd1, BASE_RESET, r);
        issue(REQ_GET + 3'd2, BASE_RESET, r);
        issue(REQ_GET + 3'd3, BASE_RESET, r);
        issue(REQ_ALLOC, '0, r);
        issue(REQ_GET, {ADDR_W{1'b1}}, r);
        issue(REQ_GET, '0, r);

        // Three-page pool with an unaligned base and a partial last page: the
        // untouched pages run out and the stack is empty.
        set_region(56'h1000_0001, 56'h1000_4800);
        repeat (3) issue(REQ_ALLOC, '0, r);

        // Whole address space: the page index cap decides validity.
        set_region('0, {ADDR_W{1'b1}});
        issue(REQ_GET, ADDR_W'(NUM_PAGES) << PAGE_SHIFT, r);
        issue(REQ_GET, ADDR_W'(NUM_PAGES - 1) << PAGE_SHIFT, r);

        // Random part over several region settings, the extremes among them.
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_region(56'h4000_0123, 56'h4000_D800);
                1: set_region('0, {ADDR_W{1'b1}});
                2: set_region(56'hFF_FFFF_FFF0_0000, {ADDR_W{1'b1}});
                3: set_region({ADDR_W{1'b1}}, {ADDR_W{1'b1}});
                4: set_region(56'h1_0000_0000, '0);
                default: set_region(BASE_RESET, LIMIT_RESET);
            endcase
            no_idle = (phase % 3 == 2);
            stop_at = items_sent + 60;
            while (items_sent < stop_at)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                        page_lifecycle();
                    11, 12, 13, 14, 15, 16:
                        single_request();
                    default:
                        noise_request();
                endcase
            end
        end

        // Push one unreferenced page several times, since frees are not
        // checked for duplicates, then take a few pages back off the stack.
        no_idle = 1'b1;
        pa = pool_page_addr();
        issue(REQ_GET, pa, r);
        while (r.ref_count != 0)
            issue(REQ_DROP, pa, r);
        repeat (4) issue(REQ_FREE, pa, r);
        repeat (3) issue(REQ_ALLOC, '0, r);
        s_axis_tvalid <= 1'b0;

        while (ledger.due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES + 4) @(posedge clk);
        if (ledger.due_results.size() != 0)
            ledger.flag("results never returned", ledger.due_results.size(), '0);

        if (ledger.mismatch_count == 0)
            $display("** page_allocator_with_refcounts: PASSED **");
        else
            $display("** page_allocator_with_refcounts: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/pgalloc_pkg.sv
rtl/pgalloc_cfg.sv
rtl/pgalloc_outreg.sv
rtl/pgalloc_core.sv
rtl/page_allocator_with_refcounts.sv
tb/page_allocator_with_refcounts_tb.sv
